// File: hw/rtl/colour_fade_envelope_defines.svh
// Assertion macros shared by the colour fade envelope RTL.
`ifndef COLOUR_FADE_ENVELOPE_DEFINES_SVH
`define COLOUR_FADE_ENVELOPE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define CFE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Check that a condition implies another in the next cycle.
`define CFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// File: hw/rtl/cfe_pkg.sv
// Types and constants shared by the colour fade envelope modules.
package cfe_pkg;

   localparam int LEN_W       = 24;
   localparam int ELAPSED_W   = 26;
   localparam int DT_W        = 16;
   localparam int CH_W        = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int RSP_TDATA_W = 104;

   // Last of the twelve byte channels (three colours, four bytes each)
   localparam logic [CH_W-1:0] CH_LAST = 4'd11;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_IN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_OUT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_ONE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_TWO  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_AMB  = 3'd6;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_IN   = 2'd1,
      PH_HOLD = 2'd2,
      PH_OUT  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ZONE_IN,
      ZONE_HOLD,
      ZONE_OUT,
      ZONE_END
   } zone_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_CLASSIFY,
      ST_FOE,
      ST_DIV,
      ST_BLEND,
      ST_EMIT
   } ctl_state_type;

   // RGBA8 colour, byte 0 is A, byte 3 is R
   typedef logic [3:0][7:0] colour_type;

   typedef struct packed {
      logic [LEN_W-1:0]     fade_in_length;
      logic [LEN_W-1:0]     hold_length;
      logic [LEN_W-1:0]     fade_out_length;
      logic [LEN_W:0]       end_hold;
      logic [ELAPSED_W-1:0] end_all;
      colour_type           target;
      colour_type           origin_one;
      colour_type           origin_two;
      colour_type           origin_ambient;
   } cfg_type;

   typedef struct packed {
      logic load_item;
      logic start;
      logic clear_result;
      logic add_elapsed;
      logic classify;
      logic foe_check;
      logic div_step;
      logic blend_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic     kind;
      logic     phase_idle;
      zone_type zone;
      logic     foe_done;
      logic     div_last;
      logic     blend_last;
   } status_type;

endpackage

// File: hw/rtl/cfe_csr.sv
// Configuration registers and precomputed phase boundaries.
module cfe_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [cfe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cfe_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output cfe_pkg::cfg_type                 cfg
);
   import cfe_pkg::*;

   logic [LEN_W-1:0]     fade_in_ff, fade_in_in;
   logic [LEN_W-1:0]     hold_ff, hold_in;
   logic [LEN_W-1:0]     fade_out_ff, fade_out_in;
   colour_type           target_ff, target_in;
   colour_type           origin_one_ff, origin_one_in;
   colour_type           origin_two_ff, origin_two_in;
   colour_type           origin_amb_ff, origin_amb_in;
   logic [LEN_W:0]       end_hold_ff, end_hold_in;
   logic [ELAPSED_W-1:0] end_all_ff, end_all_in;

   // Decode the register write; unknown indexes drop the write
   always_comb begin
      fade_in_in    = fade_in_ff;
      hold_in       = hold_ff;
      fade_out_in   = fade_out_ff;
      target_in     = target_ff;
      origin_one_in = origin_one_ff;
      origin_two_in = origin_two_ff;
      origin_amb_in = origin_amb_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FADE_IN:    fade_in_in    = csr_wdata[LEN_W-1:0];
            CSR_HOLD:       hold_in       = csr_wdata[LEN_W-1:0];
            CSR_FADE_OUT:   fade_out_in   = csr_wdata[LEN_W-1:0];
            CSR_TARGET:     target_in     = csr_wdata;
            CSR_ORIGIN_ONE: origin_one_in = csr_wdata;
            CSR_ORIGIN_TWO: origin_two_in = csr_wdata;
            CSR_ORIGIN_AMB: origin_amb_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Phase boundaries are registered and follow the length registers in the next cycle
   assign end_hold_in = {1'b0, fade_in_ff} + {1'b0, hold_ff};
   assign end_all_in  = ELAPSED_W'(fade_in_ff) + ELAPSED_W'(hold_ff)
                        + ELAPSED_W'(fade_out_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_in_ff    <= '0;
         hold_ff       <= '0;
         fade_out_ff   <= '0;
         target_ff     <= '0;
         origin_one_ff <= '0;
         origin_two_ff <= '0;
         origin_amb_ff <= '0;
         end_hold_ff   <= '0;
         end_all_ff    <= '0;
      end else begin
         fade_in_ff    <= fade_in_in;
         hold_ff       <= hold_in;
         fade_out_ff   <= fade_out_in;
         target_ff     <= target_in;
         origin_one_ff <= origin_one_in;
         origin_two_ff <= origin_two_in;
         origin_amb_ff <= origin_amb_in;
         end_hold_ff   <= end_hold_in;
         end_all_ff    <= end_all_in;
      end
   end

   assign cfg.fade_in_length  = fade_in_ff;
   assign cfg.hold_length     = hold_ff;
   assign cfg.fade_out_length = fade_out_ff;
   assign cfg.end_hold        = end_hold_ff;
   assign cfg.end_all         = end_all_ff;
   assign cfg.target          = target_ff;
   assign cfg.origin_one      = origin_one_ff;
   assign cfg.origin_two      = origin_two_ff;
   assign cfg.origin_ambient  = origin_amb_ff;

endmodule

// File: hw/rtl/cfe_datapath.sv
// Envelope state, fraction divider, shared channel blender and result register.
`include "colour_fade_envelope_defines.svh"

module cfe_datapath #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cfe_pkg::cfg_type             cfg,
   input  cfe_pkg::cmd_type             cmd,
   output cfe_pkg::status_type          status,
   input  logic                         in_kind,
   input  logic [cfe_pkg::DT_W-1:0]     in_delta,
   output cfe_pkg::phase_type           out_phase,
   output logic                         out_valid,
   output cfe_pkg::colour_type          out_one,
   output cfe_pkg::colour_type          out_two,
   output cfe_pkg::colour_type          out_amb
);
   import cfe_pkg::*;

   localparam int CNT_W = $clog2(FRACTION_BITS);

   logic                     kind_ff, kind_in;
   logic [DT_W-1:0]          dt_ff, dt_in;
   phase_type                phase_ff, phase_in;
   logic [ELAPSED_W-1:0]     elapsed_ff, elapsed_in;
   logic [LEN_W-1:0]         foe_ff, foe_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [LEN_W-1:0]         rem_ff, rem_in;
   logic [FRACTION_BITS-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     dir_ff, dir_in;
   logic [CH_W-1:0]          ch_ff, ch_in;
   colour_type               res_one_ff, res_one_in;
   colour_type               res_two_ff, res_two_in;
   colour_type               res_amb_ff, res_amb_in;
   logic                     col_valid_ff, col_valid_in;
   phase_type                out_phase_ff, out_phase_in;
   logic                     out_valid_ff, out_valid_in;
   colour_type               out_one_ff, out_one_in;
   colour_type               out_two_ff, out_two_in;
   colour_type               out_amb_ff, out_amb_in;

   logic [ELAPSED_W:0]       elapsed_sum;
   logic [ELAPSED_W-1:0]     elapsed_sat;
   logic [LEN_W:0]           foe_sum;
   logic [LEN_W-1:0]         foe_sat;
   zone_type                 zone;
   logic                     foe_done;
   logic [LEN_W:0]           rem_dbl;
   logic [LEN_W:0]           rem_sub;
   logic                     rem_ge;
   colour_type               origin_sel;
   logic [7:0]               byte_a;
   logic [7:0]               byte_b;
   logic signed [8:0]        byte_diff;
   logic signed [FRACTION_BITS:0]   frac_s;
   logic signed [FRACTION_BITS+9:0] prod;
   logic [7:0]               blended;

   // Saturating time accumulators
   assign elapsed_sum = {1'b0, elapsed_ff} + (ELAPSED_W+1)'(dt_ff);
   assign elapsed_sat = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
   assign foe_sum     = {1'b0, foe_ff} + (LEN_W+1)'(dt_ff);
   assign foe_sat     = foe_sum[LEN_W] ? '1 : foe_sum[LEN_W-1:0];

   // Locate the elapsed time among the phase boundaries
   always_comb begin
      priority if (elapsed_ff < ELAPSED_W'(cfg.fade_in_length)) begin
         zone = ZONE_IN;
      end else if (elapsed_ff < ELAPSED_W'(cfg.end_hold)) begin
         zone = ZONE_HOLD;
      end else if (elapsed_ff < cfg.end_all) begin
         zone = ZONE_OUT;
      end else begin
         zone = ZONE_END;
      end
   end

   assign foe_done = (foe_ff >= cfg.fade_out_length);

   // One restoring division step: one fraction bit per cycle
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_sub = rem_dbl - {1'b0, len_ff};
   assign rem_ge  = (rem_dbl >= {1'b0, len_ff});

   // Pick the origin colour of the channel being blended
   always_comb begin
      unique case (ch_ff[CH_W-1:2])
         2'd0:    origin_sel = cfg.origin_one;
         2'd1:    origin_sel = cfg.origin_two;
         default: origin_sel = cfg.origin_ambient;
      endcase
   end

   // Blend one byte: a + floor((b - a) * f / 2^FB)
   assign byte_a    = dir_ff ? cfg.target[ch_ff[1:0]] : origin_sel[ch_ff[1:0]];
   assign byte_b    = dir_ff ? origin_sel[ch_ff[1:0]] : cfg.target[ch_ff[1:0]];
   assign byte_diff = $signed({1'b0, byte_b}) - $signed({1'b0, byte_a});
   assign frac_s    = $signed({1'b0, quo_ff});
   assign prod      = byte_diff * frac_s;
   assign blended   = byte_a + prod[FRACTION_BITS+7:FRACTION_BITS];

   always_comb begin
      kind_in      = kind_ff;
      dt_in        = dt_ff;
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      foe_in       = foe_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      dir_in       = dir_ff;
      ch_in        = ch_ff;
      res_one_in   = res_one_ff;
      res_two_in   = res_two_ff;
      res_amb_in   = res_amb_ff;
      col_valid_in = col_valid_ff;
      out_phase_in = out_phase_ff;
      out_valid_in = out_valid_ff;
      out_one_in   = out_one_ff;
      out_two_in   = out_two_ff;
      out_amb_in   = out_amb_ff;

      // Capture the accepted transaction
      if (cmd.load_item) begin
         kind_in = in_kind;
         dt_in   = in_delta;
      end

      // Restart the effect
      if (cmd.start) begin
         phase_in     = PH_IN;
         elapsed_in   = '0;
         foe_in       = '0;
         res_one_in   = '0;
         res_two_in   = '0;
         res_amb_in   = '0;
         col_valid_in = 1'b0;
      end

      // Tick while idle gives an empty result
      if (cmd.clear_result) begin
         res_one_in   = '0;
         res_two_in   = '0;
         res_amb_in   = '0;
         col_valid_in = 1'b0;
      end

      if (cmd.add_elapsed) begin
         elapsed_in = elapsed_sat;
      end

      // Apply the phase that the new elapsed time falls in
      if (cmd.classify) begin
         unique case (zone)
            ZONE_IN: begin
               phase_in     = PH_IN;
               col_valid_in = 1'b1;
               len_in       = cfg.fade_in_length;
               rem_in       = elapsed_ff[LEN_W-1:0];
               quo_in       = '0;
               cnt_in       = CNT_W'(FRACTION_BITS - 1);
               dir_in       = 1'b0;
               ch_in        = '0;
            end
            ZONE_HOLD: begin
               phase_in     = PH_HOLD;
               res_one_in   = '0;
               res_two_in   = '0;
               res_amb_in   = '0;
               col_valid_in = 1'b0;
            end
            ZONE_OUT: begin
               phase_in = PH_OUT;
               foe_in   = foe_sat;
            end
            ZONE_END: begin
               phase_in     = PH_IDLE;
               elapsed_in   = '0;
               foe_in       = '0;
               res_one_in   = cfg.origin_one;
               res_two_in   = cfg.origin_two;
               res_amb_in   = cfg.origin_ambient;
               col_valid_in = 1'b1;
            end
            default: ;
         endcase
      end

      // Fade out: origins once its counter is spent, else blend back
      if (cmd.foe_check) begin
         col_valid_in = 1'b1;
         if (foe_done) begin
            res_one_in = cfg.origin_one;
            res_two_in = cfg.origin_two;
            res_amb_in = cfg.origin_ambient;
         end else begin
            len_in = cfg.fade_out_length;
            rem_in = foe_ff;
            quo_in = '0;
            cnt_in = CNT_W'(FRACTION_BITS - 1);
            dir_in = 1'b1;
            ch_in  = '0;
         end
      end

      if (cmd.div_step) begin
         rem_in = rem_ge ? rem_sub[LEN_W-1:0] : rem_dbl[LEN_W-1:0];
         quo_in = {quo_ff[FRACTION_BITS-2:0], rem_ge};
         cnt_in = cnt_ff - 1'b1;
      end

      // Write the blended byte into its colour
      if (cmd.blend_step) begin
         unique case (ch_ff[CH_W-1:2])
            2'd0:    res_one_in[ch_ff[1:0]] = blended;
            2'd1:    res_two_in[ch_ff[1:0]] = blended;
            default: res_amb_in[ch_ff[1:0]] = blended;
         endcase
         ch_in = ch_ff + 1'b1;
      end

      // Hand the finished result to the output register
      if (cmd.emit) begin
         out_phase_in = phase_ff;
         out_valid_in = col_valid_ff;
         out_one_in   = res_one_ff;
         out_two_in   = res_two_ff;
         out_amb_in   = res_amb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
         foe_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         foe_ff     <= foe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      dt_ff        <= dt_in;
      len_ff       <= len_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      dir_ff       <= dir_in;
      ch_ff        <= ch_in;
      res_one_ff   <= res_one_in;
      res_two_ff   <= res_two_in;
      res_amb_ff   <= res_amb_in;
      col_valid_ff <= col_valid_in;
      out_phase_ff <= out_phase_in;
      out_valid_ff <= out_valid_in;
      out_one_ff   <= out_one_in;
      out_two_ff   <= out_two_in;
      out_amb_ff   <= out_amb_in;
   end

   assign status.kind       = kind_ff;
   assign status.phase_idle = (phase_ff == PH_IDLE);
   assign status.zone       = zone;
   assign status.foe_done   = foe_done;
   assign status.div_last   = (cnt_ff == '0);
   assign status.blend_last = (ch_ff == CH_LAST);

   assign out_phase = out_phase_ff;
   assign out_valid = out_valid_ff;
   assign out_one   = out_one_ff;
   assign out_two   = out_two_ff;
   assign out_amb   = out_amb_ff;

   `CFE_ASSERT_SAME(a_div_rem_below_len, clock, reset, cmd.div_step, rem_ff < len_ff)
   `CFE_ASSERT_SAME(a_blend_channel_range, clock, reset, cmd.blend_step, ch_ff <= CH_LAST)
   `CFE_ASSERT_NEXT(a_end_clears_time, clock, reset, cmd.classify && (zone == ZONE_END), (elapsed_ff == '0) && (foe_ff == '0) && (phase_ff == PH_IDLE))

endmodule

// File: hw/rtl/cfe_ctl.sv
// Sequencing state machine and result handshake of the colour fade envelope.
`include "colour_fade_envelope_defines.svh"

module cfe_ctl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  cfe_pkg::status_type  status,
   output cfe_pkg::cmd_type     cmd
);
   import cfe_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic          slot_free;

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   // Next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_ADD;
            end
         end
         ST_ADD: begin
            priority if (status.kind) begin
               cmd.start = 1'b1;
               state_in  = ST_EMIT;
            end else if (status.phase_idle) begin
               cmd.clear_result = 1'b1;
               state_in         = ST_EMIT;
            end else begin
               cmd.add_elapsed = 1'b1;
               state_in        = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            unique case (status.zone)
               ZONE_IN:  state_in = ST_DIV;
               ZONE_OUT: state_in = ST_FOE;
               default:  state_in = ST_EMIT;
            endcase
         end
         ST_FOE: begin
            cmd.foe_check = 1'b1;
            state_in      = status.foe_done ? ST_EMIT : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            cmd.blend_step = 1'b1;
            if (status.blend_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result valid until the consumer takes it
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (cmd.emit) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   `CFE_ASSERT_NEXT(a_accept_goes_to_add, clock, reset, req_tvalid && req_tready, state_ff == ST_ADD)
   `CFE_ASSERT_NEXT(a_fade_in_divides, clock, reset, (state_ff == ST_CLASSIFY) && (status.zone == ZONE_IN), state_ff == ST_DIV)
   `CFE_ASSERT_NEXT(a_emit_shows_result, clock, reset, (state_ff == ST_EMIT) && slot_free, rsp_tvalid_ff && (state_ff == ST_IDLE))

endmodule

// File: hw/rtl/colour_fade_envelope.sv
// Top level of the fade-in, hold and fade-out colour envelope.
//
// Each request transaction is either a start (tuser = 1) or a time tick
// carrying delta_time, and gives exactly one response transaction with the
// phase after the item, a colour-valid flag and three RGBA8 colours. Items
// are taken one at a time. A start or a tick while idle goes from the add
// state straight to emit, a tick that lands in hold or ends the effect also
// passes the classify state, and a fade-out tick whose counter is spent
// passes the fade-out check too. A blended tick runs a restoring divider for
// the fraction, one bit per cycle, then one shared byte multiplier over the
// twelve colour channels, after the fade-out check when in fade out. A
// response waiting in the output register stalls only the final hand-off,
// not acceptance.
module colour_fade_envelope #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,  // [15:0] delta_time
   input  logic                               req_tuser,  // [0] kind
   // Response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [1:0] phase_now, [33:2] light_one_colour, [65:34] light_two_colour,
   // [97:66] ambient_colour, [103:98] zero
   output logic [cfe_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,  // [0] colour_valid
   // Configuration port
   input  logic                               csr_we,
   input  logic [cfe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cfe_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cfe_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   phase_type  out_phase;
   logic       out_valid;
   colour_type out_one;
   colour_type out_two;
   colour_type out_amb;

   cfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cfe_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cfe_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .in_kind   (req_tuser),
      .in_delta  (req_tdata),
      .out_phase (out_phase),
      .out_valid (out_valid),
      .out_one   (out_one),
      .out_two   (out_two),
      .out_amb   (out_amb)
   );

   // Pack the response fields, lowest field first
   assign rsp_tdata = {6'b0, out_amb, out_two, out_one, out_phase};
   assign rsp_tuser = out_valid;

endmodule

// File: verif/colour_fade_envelope_test.sv
// Self-checking testbench for the fade-in, hold and fade-out colour envelope.
`timescale 1ns / 1ps

module colour_fade_envelope_test;
   import cfe_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam logic [63:0] ELAPSED_LIMIT = 64'h3FF_FFFF;
   localparam logic [63:0] FADE_OUT_LIMIT = 64'hFF_FFFF;
   localparam logic [63:0] LEN_FULL = 64'hFF_FFFF;
   // Index past the end of the register list, writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic        kind;
      logic [15:0] delta;
   } tick_item_t;

   typedef struct packed {
      phase_type  phase_now;
      logic       colour_valid;
      colour_type light_one;
      colour_type light_two;
      colour_type ambient;
   } envelope_out_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Stimulus and scoreboard storage
   tick_item_t    tick_queue[$];
   envelope_out_t predicted_outputs[$];
   int            error_count = 0;
   bit            idle_enable = 1'b1;
   bit            req_fired = 1'b0;
   int            req_gap = 0;
   int            rsp_hold = 0;

   // Predictor copy of the registers
   logic [LEN_W-1:0] cfg_fade_in = '0;
   logic [LEN_W-1:0] cfg_hold = '0;
   logic [LEN_W-1:0] cfg_fade_out = '0;
   colour_type       cfg_target = '0;
   colour_type       cfg_origin_one = '0;
   colour_type       cfg_origin_two = '0;
   colour_type       cfg_origin_amb = '0;

   // Predictor copy of the envelope state
   phase_type            env_phase = PH_IDLE;
   logic [ELAPSED_W-1:0] env_elapsed = '0;
   logic [LEN_W-1:0]     env_fade_out_elapsed = '0;

   colour_fade_envelope #(
      .FRACTION_BITS(FRAC_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Blend fraction of t over len, truncated to FRAC_BITS
   function automatic logic [63:0] fade_fraction(input logic [63:0] t, input logic [63:0] len);
      logic [63:0] f;
      if (len == 0) return 64'd0;
      f = (t << FRAC_BITS) / len;
      if (f > ((64'd1 << FRAC_BITS) - 1)) f = (64'd1 << FRAC_BITS) - 1;
      return f;
   endfunction

   // Truncated linear blend of each byte channel
   function automatic colour_type mix_colour(input colour_type from, input colour_type to,
                                             input logic [63:0] f);
      colour_type  res;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      for (int i = 0; i < 4; i++) begin
         a = 64'(from[i]);
         b = 64'(to[i]);
         c = (a * ((64'd1 << FRAC_BITS) - f) + b * f) >> FRAC_BITS;
         res[i] = c[7:0];
      end
      return res;
   endfunction

   // Advance the envelope by one request and return the response it causes
   function automatic envelope_out_t advance_envelope(input logic kind, input logic [15:0] dt);
      envelope_out_t r;
      logic [63:0]   end_in;
      logic [63:0]   end_hold;
      logic [63:0]   end_all;
      logic [63:0]   el;
      logic [63:0]   foe;
      logic [63:0]   f;
      r = '0;
      r.phase_now = PH_IDLE;
      end_in = 64'(cfg_fade_in);
      end_hold = end_in + 64'(cfg_hold);
      end_all = end_hold + 64'(cfg_fade_out);
      if (kind) begin
         env_phase = PH_IN;
         env_elapsed = '0;
         env_fade_out_elapsed = '0;
      end else if (env_phase != PH_IDLE) begin
         el = 64'(env_elapsed) + 64'(dt);
         if (el > ELAPSED_LIMIT) el = ELAPSED_LIMIT;
         env_elapsed = el[ELAPSED_W-1:0];
         if (el < end_in) begin
            f = fade_fraction(el, 64'(cfg_fade_in));
            env_phase = PH_IN;
            r.colour_valid = 1'b1;
            r.light_one = mix_colour(cfg_origin_one, cfg_target, f);
            r.light_two = mix_colour(cfg_origin_two, cfg_target, f);
            r.ambient = mix_colour(cfg_origin_amb, cfg_target, f);
         end else if (el < end_hold) begin
            env_phase = PH_HOLD;
         end else if (el < end_all) begin
            env_phase = PH_OUT;
            foe = 64'(env_fade_out_elapsed) + 64'(dt);
            if (foe > FADE_OUT_LIMIT) foe = FADE_OUT_LIMIT;
            env_fade_out_elapsed = foe[LEN_W-1:0];
            r.colour_valid = 1'b1;
            if (foe >= 64'(cfg_fade_out)) begin
               // fade-out counter spent: origins again
               r.light_one = cfg_origin_one;
               r.light_two = cfg_origin_two;
               r.ambient = cfg_origin_amb;
            end else begin
               f = fade_fraction(foe, 64'(cfg_fade_out));
               r.light_one = mix_colour(cfg_target, cfg_origin_one, f);
               r.light_two = mix_colour(cfg_target, cfg_origin_two, f);
               r.ambient = mix_colour(cfg_target, cfg_origin_amb, f);
            end
         end else begin
            // effect over: back to idle, emit origins once
            env_phase = PH_IDLE;
            env_elapsed = '0;
            env_fade_out_elapsed = '0;
            r.colour_valid = 1'b1;
            r.light_one = cfg_origin_one;
            r.light_two = cfg_origin_two;
            r.ambient = cfg_origin_amb;
         end
      end
      r.phase_now = env_phase;
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", field, want, got);
         error_count++;
      end
   endtask

   // Request driver: hold until the transaction is taken, then fetch the next
   always @(negedge clock) begin
      tick_item_t item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (tick_queue.size() > 0) begin
            item = tick_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= item.kind;
            req_tdata <= item.delta;
            if (idle_enable && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 17);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response back-pressure in random bursts
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 11) == 0) begin
         rsp_hold = $urandom_range(1, 17) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: check each response, then predict each accepted request
   always @(posedge clock) begin
      envelope_out_t want;
      req_fired = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_outputs.size() == 0) begin
               $error("response transaction with no prediction pending");
               error_count++;
            end else begin
               want = predicted_outputs.pop_front();
               compare_field("phase_now", 32'(want.phase_now), 32'(rsp_tdata[1:0]));
               compare_field("colour_valid", 32'(want.colour_valid), 32'(rsp_tuser));
               compare_field("light_one_colour", want.light_one, rsp_tdata[33:2]);
               compare_field("light_two_colour", want.light_two, rsp_tdata[65:34]);
               compare_field("ambient_colour", want.ambient, rsp_tdata[97:66]);
            end
         end
         if (req_tvalid && req_tready) begin
            predicted_outputs.push_back(advance_envelope(req_tuser, req_tdata));
            req_fired = 1'b1;
         end
      end
   end

   // Write one register and mirror it into the predictor
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_FADE_IN:    cfg_fade_in = value[LEN_W-1:0];
         CSR_HOLD:       cfg_hold = value[LEN_W-1:0];
         CSR_FADE_OUT:   cfg_fade_out = value[LEN_W-1:0];
         CSR_TARGET:     cfg_target = value;
         CSR_ORIGIN_ONE: cfg_origin_one = value;
         CSR_ORIGIN_TWO: cfg_origin_two = value;
         CSR_ORIGIN_AMB: cfg_origin_amb = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every queued transaction is taken and answered; look a little
   // after the falling edge so the driver's updates have landed
   task automatic wait_drained();
      do begin
         @(negedge clock);
         #1;
      end while (tick_queue.size() != 0 || req_tvalid || predicted_outputs.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_colour();
      case ($urandom_range(0, 3))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Queue start-then-tick sequences until the effect ends or the budget runs out
   task automatic queue_effects(input int budget, input longint span, input int lo,
                                input int hi, input bit noisy);
      int     count;
      int     r;
      longint run;
      bit     done;
      logic [15:0] dt;
      count = 0;
      while (count < budget) begin
         tick_queue.push_back('{kind: 1'b1, delta: 16'($urandom)});
         count++;
         run = 0;
         done = 1'b0;
         while (!done && count < budget) begin
            r = $urandom_range(0, 99);
            if (noisy && r < 4) begin
               // restart in the middle of a running effect
               tick_queue.push_back('{kind: 1'b1, delta: 16'($urandom)});
               run = 0;
            end else begin
               if (noisy && r < 10) dt = 16'($urandom);
               else dt = 16'($urandom_range(lo, hi));
               tick_queue.push_back('{kind: 1'b0, delta: dt});
               run += dt;
               if (run >= span) done = 1'b1;
            end
            count++;
         end
         // a few ticks while idle
         repeat ($urandom_range(0, 2)) begin
            tick_queue.push_back('{kind: 1'b0, delta: 16'($urandom)});
            count++;
         end
      end
   endtask

   // Program a full register set, lengths with junk in the unused top bits
   task automatic program_setting(input logic [LEN_W-1:0] fin, input logic [LEN_W-1:0] hld,
                                  input logic [LEN_W-1:0] fout);
      write_register(CSR_FADE_IN, {8'($urandom), fin});
      write_register(CSR_HOLD, {8'($urandom), hld});
      write_register(CSR_FADE_OUT, {8'($urandom), fout});
      write_register(CSR_TARGET, pick_colour());
      write_register(CSR_ORIGIN_ONE, pick_colour());
      write_register(CSR_ORIGIN_TWO, pick_colour());
      write_register(CSR_ORIGIN_AMB, pick_colour());
      if ($urandom_range(0, 3) == 0) write_register(CSR_UNUSED, $urandom);
   endtask

   function automatic int tick_ceiling(input longint span);
      longint hi;
      hi = span / 4 + 1;
      if (hi > 65535) hi = 65535;
      return int'(hi);
   endfunction

   // Main sequence
   initial begin
      logic [LEN_W-1:0] fin;
      logic [LEN_W-1:0] hld;
      logic [LEN_W-1:0] fout;
      longint           span;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Reset registers: idle ticks, then an effect with every phase empty
      tick_queue.push_back('{kind: 1'b0, delta: 16'h0000});
      tick_queue.push_back('{kind: 1'b0, delta: 16'hFFFF});
      tick_queue.push_back('{kind: 1'b1, delta: 16'hFFFF});
      tick_queue.push_back('{kind: 1'b0, delta: 16'h0000});
      tick_queue.push_back('{kind: 1'b0, delta: 16'h1234});
      wait_drained();

      // Fixed lengths 100 / 50 / 80 with known colours
      write_register(CSR_FADE_IN, 32'hFF00_0064);
      write_register(CSR_HOLD, 32'h0000_0032);
      write_register(CSR_FADE_OUT, 32'hA500_0050);
      write_register(CSR_TARGET, 32'hFFFF_FFFF);
      write_register(CSR_ORIGIN_ONE, 32'h0000_0000);
      write_register(CSR_ORIGIN_TWO, 32'h1234_5678);
      write_register(CSR_ORIGIN_AMB, 32'h80FF_0140);
      write_register(CSR_UNUSED, 32'hDEAD_BEEF);
      tick_queue.push_back('{kind: 1'b1, delta: 16'h0000});
      tick_queue.push_back('{kind: 1'b0, delta: 16'd0});   // fraction zero
      tick_queue.push_back('{kind: 1'b0, delta: 16'd99});  // fraction at its top
      tick_queue.push_back('{kind: 1'b1, delta: 16'hFFFF}); // restart mid-effect
      tick_queue.push_back('{kind: 1'b0, delta: 16'd50});
      tick_queue.push_back('{kind: 1'b0, delta: 16'd60});  // into hold
      tick_queue.push_back('{kind: 1'b0, delta: 16'd40});  // into fade out
      tick_queue.push_back('{kind: 1'b0, delta: 16'd79});  // counter spent
      tick_queue.push_back('{kind: 1'b0, delta: 16'd1});   // end of effect
      tick_queue.push_back('{kind: 1'b0, delta: 16'd5});   // idle
      tick_queue.push_back('{kind: 1'b1, delta: 16'h5555});
      tick_queue.push_back('{kind: 1'b0, delta: 16'hFFFF}); // straight to the end
      tick_queue.push_back('{kind: 1'b1, delta: 16'hAAAA});
      tick_queue.push_back('{kind: 1'b0, delta: 16'd100}); // skip fade in at its edge
      tick_queue.push_back('{kind: 1'b0, delta: 16'd50});
      tick_queue.push_back('{kind: 1'b0, delta: 16'd80});
      wait_drained();

      // Random settings, well-formed effects with some noise
      for (int s = 0; s < 12; s++) begin
         case (s % 4)
            0: begin
               fin = ($urandom_range(0, 4) == 0) ? '0 : LEN_W'($urandom_range(1, 400));
               hld = ($urandom_range(0, 4) == 0) ? '0 : LEN_W'($urandom_range(1, 400));
               fout = ($urandom_range(0, 4) == 0) ? '0 : LEN_W'($urandom_range(1, 400));
            end
            1: begin
               fin = LEN_W'($urandom_range(0, 5000));
               hld = LEN_W'($urandom_range(0, 5000));
               fout = LEN_W'($urandom_range(0, 5000));
            end
            2: begin
               fin = LEN_W'($urandom_range(1, 8));
               hld = LEN_W'($urandom_range(0, 8));
               fout = LEN_W'($urandom_range(1, 8));
            end
            default: begin
               fin = LEN_W'($urandom_range(0, 200000));
               hld = LEN_W'($urandom_range(0, 200000));
               fout = LEN_W'($urandom_range(0, 200000));
            end
         endcase
         program_setting(fin, hld, fout);
         span = longint'(fin) + longint'(hld) + longint'(fout);
         queue_effects(55, span, 0, tick_ceiling(span), 1'b1);
         wait_drained();
      end

      // Longest effect, every length at its maximum
      program_setting(LEN_FULL[LEN_W-1:0], LEN_FULL[LEN_W-1:0], LEN_FULL[LEN_W-1:0]);
      span = 3 * longint'(LEN_FULL);
      queue_effects(830, span, 60000, 65535, 1'b0);
      wait_drained();

      // Closing stretch without idling on either side
      idle_enable = 1'b0;
      fin = LEN_W'($urandom_range(1, 300));
      hld = LEN_W'($urandom_range(0, 300));
      fout = LEN_W'($urandom_range(1, 300));
      program_setting(fin, hld, fout);
      span = longint'(fin) + longint'(hld) + longint'(fout);
      queue_effects(30, span, 0, tick_ceiling(span), 1'b1);
      wait_drained();
      repeat (40) @(negedge clock);

      if (error_count == 0 && predicted_outputs.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(4_000_000);
      $display("Test completed with failures");
      $finish;
   end

endmodule
